/* src/b58sd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b58sd_pkg
// Types, constants and the alphabet lookup shared by the Base58 decoder files.
// ----------------------------------------------------------------------------
package b58sd_pkg;

  // digit carry between byte cells, at most 57
  localparam int CARRY_W = 6;
  // byte * 58 + carry, at most 14847
  localparam int PROD_W  = 14;
  localparam int RADIX   = 58;
  localparam logic [7:0] CHAR_ONE = 8'h31;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // input transaction payload
  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    status_e    status;
  } out_item_t;

  // digit token travelling from the low byte cell towards the high one
  typedef struct packed {
    logic               valid;
    logic [CARRY_W-1:0] carry;
  } tok_t;

  // control to every byte cell
  typedef struct packed {
    logic clear;
    logic shift;
  } ctl_t;

  // alphabet lookup: {ok, digit}
  function automatic logic [CARRY_W:0] b58_digit(input logic [7:0] code);
    logic [7:0] d;
    logic       ok;
    ok = 1'b1;
    d  = 8'd0;
    priority if (code >= 8'h31 && code <= 8'h39) begin
      d = code - 8'h31;
    end else if (code >= 8'h41 && code <= 8'h48) begin
      d = code - 8'h38;
    end else if (code >= 8'h4A && code <= 8'h4E) begin
      d = code - 8'h39;
    end else if (code >= 8'h50 && code <= 8'h5A) begin
      d = code - 8'h3A;
    end else if (code >= 8'h61 && code <= 8'h6B) begin
      d = code - 8'h40;
    end else if (code >= 8'h6D && code <= 8'h7A) begin
      d = code - 8'h41;
    end else begin
      ok = 1'b0;
    end
    return {ok, d[CARRY_W-1:0]};
  endfunction

endpackage
`default_nettype wire

/* src/b58sd_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b58sd_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface b58sd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/b58sd_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b58sd_cell
// One byte of the number store: multiply by 58 plus incoming carry, or shift.
// ----------------------------------------------------------------------------
module b58sd_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire b58sd_pkg::ctl_t ctl_i,
  input  wire b58sd_pkg::tok_t tok_i,
  input  wire logic [7:0]      shift_byte_i,
  output b58sd_pkg::tok_t      tok_o,
  output logic [7:0]           byte_o
);
  import b58sd_pkg::*;

  logic [7:0]        byte_q;
  tok_t              tok_q;
  logic [PROD_W-1:0] prod;

  // multiply-add for the digit token passing through
  assign prod = PROD_W'(byte_q) * PROD_W'(RADIX) + PROD_W'(tok_i.carry);

  // byte register and outgoing token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
      tok_q  <= '0;
    end else if (ctl_i.clear) begin
      byte_q <= 8'd0;
      tok_q  <= '0;
    end else if (ctl_i.shift) begin
      byte_q      <= shift_byte_i;
      tok_q.valid <= 1'b0;
    end else if (tok_i.valid) begin
      byte_q      <= prod[7:0];
      tok_q.valid <= 1'b1;
      tok_q.carry <= prod[PROD_W-1:8];
    end else begin
      tok_q.valid <= 1'b0;
    end
  end

  assign tok_o  = tok_q;
  assign byte_o = byte_q;

endmodule
`default_nettype wire

/* src/b58sd_chain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b58sd_chain
// Row of byte cells, index 0 most significant; tokens enter at the low end.
// ----------------------------------------------------------------------------
module b58sd_chain #(
  parameter int MAX_BYTES = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire b58sd_pkg::ctl_t ctl_i,
  input  wire b58sd_pkg::tok_t tok_i,
  output b58sd_pkg::tok_t      tok_o,
  output logic [7:0]           msb_byte_o
);
  import b58sd_pkg::*;

  tok_t       tok_w  [MAX_BYTES];
  logic [7:0] byte_w [MAX_BYTES];

  // cells, each fed by its lower neighbour, the lowest one by tok_i
  for (genvar j = 0; j < MAX_BYTES; j++) begin : g_cell
    if (j == MAX_BYTES - 1) begin : g_low
      b58sd_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl_i),
        .tok_i        (tok_i),
        .shift_byte_i (8'd0),
        .tok_o        (tok_w[j]),
        .byte_o       (byte_w[j])
      );
    end else begin : g_mid
      b58sd_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl_i),
        .tok_i        (tok_w[j+1]),
        .shift_byte_i (byte_w[j+1]),
        .tok_o        (tok_w[j]),
        .byte_o       (byte_w[j])
      );
    end
  end

  assign tok_o      = tok_w[0];
  assign msb_byte_o = byte_w[0];

endmodule
`default_nettype wire

/* src/base58_string_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// base58_string_decoder
// Base58 (Bitcoin alphabet) string to byte decoder built on a byte cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one character per transaction, final_char set on the last
//   one. Characters are taken one per cycle while a string is collected;
//   each digit ripples through the chain of MAX_BYTES cells, one cell a cycle.
//   After the final character the input is held off: the chain drains, then
//   leading zero bytes of the store are shifted out, then results leave on
//   out_o at one per cycle while out_o is ready, leading zero bytes first,
//   last_byte on the final one. An error string gives one result with
//   data_byte 0, last_byte 1 and the error status. The next string is taken
//   after the last result is loaded into the output register.
//   out_o is driven from an output register; a stall holds the result and
//   pauses the readout. Reset clears the store, the counters and the channels.
// ----------------------------------------------------------------------------
module base58_string_decoder #(
  parameter int MAX_BYTES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  b58sd_chan_if.sink   in_i,
  b58sd_chan_if.source out_o
);
  import b58sd_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam logic [CW-1:0] NB    = CW'(MAX_BYTES);
  localparam logic [CW-1:0] NB_M1 = CW'(MAX_BYTES - 1);

  typedef enum logic [2:0] {
    S_RUN,
    S_DRAIN,
    S_SKIP,
    S_EMIT,
    S_ONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] lz_q;
  logic [CW-1:0] zrem_q;
  logic [CW-1:0] tot_q;
  logic          lead_q;
  logic          inv_q;
  logic          ovf_q;
  status_e       one_status_q;
  logic          out_valid_q;
  out_item_t     out_q;

  ctl_t             ctl;
  tok_t             tok_in;
  tok_t             tok_top;
  logic [7:0]       msb_byte;
  logic [CARRY_W:0] dig;
  logic             accept;
  logic             is_one;
  logic             out_free;
  logic             skip_done;

  assign in_i.ready    = (state_q == S_RUN);
  assign accept        = in_i.valid && in_i.ready;
  assign dig           = b58_digit(in_i.payload.char_code);
  assign is_one        = lead_q && (in_i.payload.char_code == CHAR_ONE);
  assign out_free      = !out_valid_q || out_o.ready;
  assign skip_done     = (cnt_q == NB) || (msb_byte != 8'd0);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // digit injection at the low end of the chain
  always_comb begin
    tok_in.valid = accept && !inv_q && !ovf_q && !is_one && dig[CARRY_W];
    tok_in.carry = dig[CARRY_W-1:0];
  end

  // chain control: shift during zero skip and readout, clear at string end
  always_comb begin
    ctl.shift = ((state_q == S_SKIP) && !skip_done) ||
                ((state_q == S_EMIT) && out_free && (zrem_q == '0));
    ctl.clear = out_free && ((state_q == S_ONE) ||
                ((state_q == S_EMIT) && (tot_q == CW'(1))));
  end

  b58sd_chain #(
    .MAX_BYTES (MAX_BYTES)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .tok_i      (tok_in),
    .tok_o      (tok_top),
    .msb_byte_o (msb_byte)
  );

  // sequencer, per-string state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_RUN;
      cnt_q        <= '0;
      lz_q         <= '0;
      zrem_q       <= '0;
      tot_q        <= '0;
      lead_q       <= 1'b1;
      inv_q        <= 1'b0;
      ovf_q        <= 1'b0;
      one_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // carry out of the most significant cell
      if (tok_top.valid && (tok_top.carry != '0)) begin
        ovf_q <= 1'b1;
      end
      unique case (state_q)
        S_RUN: begin
          if (accept) begin
            if (!inv_q && !ovf_q) begin
              if (is_one) begin
                if (lz_q >= NB) begin
                  ovf_q <= 1'b1;
                end else begin
                  lz_q <= lz_q + CW'(1);
                end
              end else begin
                lead_q <= 1'b0;
                if (!dig[CARRY_W]) begin
                  inv_q <= 1'b1;
                end
              end
            end
            if (in_i.payload.final_char) begin
              state_q <= S_DRAIN;
              cnt_q   <= '0;
            end
          end
        end
        S_DRAIN: begin
          if (cnt_q == NB_M1) begin
            state_q <= S_SKIP;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_SKIP: begin
          // an earlier error wins over an output that is too long
          if (!skip_done) begin
            cnt_q <= cnt_q + CW'(1);
          end else if (ovf_q) begin
            one_status_q <= ST_OVERFLOW;
            state_q      <= S_ONE;
          end else if (inv_q) begin
            one_status_q <= ST_INVALID;
            state_q      <= S_ONE;
          end else if (lz_q > cnt_q) begin
            one_status_q <= ST_OVERFLOW;
            state_q      <= S_ONE;
          end else if ((lz_q == '0) && (cnt_q == NB)) begin
            one_status_q <= ST_OK;
            state_q      <= S_ONE;
          end else begin
            tot_q   <= lz_q + (NB - cnt_q);
            zrem_q  <= lz_q;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.last_byte <= (tot_q == CW'(1));
            out_q.status    <= ST_OK;
            if (zrem_q != '0) begin
              out_q.data_byte <= 8'd0;
              zrem_q          <= zrem_q - CW'(1);
            end else begin
              out_q.data_byte <= msb_byte;
            end
            tot_q <= tot_q - CW'(1);
            if (tot_q == CW'(1)) begin
              state_q <= S_RUN;
              lz_q    <= '0;
              lead_q  <= 1'b1;
              inv_q   <= 1'b0;
              ovf_q   <= 1'b0;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.data_byte <= 8'd0;
            out_q.last_byte <= 1'b1;
            out_q.status    <= one_status_q;
            state_q         <= S_RUN;
            lz_q            <= '0;
            lead_q          <= 1'b1;
            inv_q           <= 1'b0;
            ovf_q           <= 1'b0;
          end
        end
        default: begin
          state_q <= S_RUN;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // no digit enters the chain outside string collection
  a_inject_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RUN) |-> !tok_in.valid)
    else $error("digit injected outside collection");

  // an error result is always a single zero byte closing the string
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK)) |-> (out_q.last_byte && (out_q.data_byte == 8'd0)))
    else $error("malformed error result");

  // the final character always starts the drain
  a_final_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.payload.final_char) |=> (state_q == S_DRAIN))
    else $error("final character did not start drain");

  // readout counters stay consistent
  a_emit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ((tot_q != '0) && (zrem_q <= tot_q)))
    else $error("readout counters out of range");
`endif

endmodule
`default_nettype wire
